>>> sv/cfac_pkg.sv
// Shared types, codes and helpers for the case-folded anagram checker.
`timescale 1ns / 1ps
`default_nettype none
package cfac_pkg;

  localparam int OP_W        = 2;
  localparam int CHAR_W      = 8;
  localparam int CNT_W       = 9;
  localparam int NZ_W        = 9;
  localparam int LEN_W       = 8;
  localparam int N_CHAR      = 1 << CHAR_W;
  localparam int MAX_LEN_DEF = 128;

  localparam logic [OP_W-1:0] OP_FIRST  = 2'd0;
  localparam logic [OP_W-1:0] OP_SECOND = 2'd1;
  localparam logic [OP_W-1:0] OP_END    = 2'd2;

  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
  localparam logic [CHAR_W-1:0] CASE_OFS = 8'd32;
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

  // Histogram command from the pipeline to the count store.
  typedef struct packed {
    logic              adv;  // pipeline advances this cycle
    logic              upd;  // apply +/-1 to entry idx
    logic              dec;  // 1: count down (second string)
    logic              clr;  // end of pair: drop all entries
    logic [CHAR_W-1:0] idx;
  } cfac_cmd_t;

  function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] ch);
    logic [CHAR_W-1:0] res;
    res = ch;
    if (ch inside {[CH_UP_A:CH_UP_Z]}) begin
      res = ch + CASE_OFS;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

>>> sv/cfac_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module cfac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> sv/cfac_count.sv
// Difference-count store: RAM, per-entry valid bits, write forwarding, nonzero tally.
`timescale 1ns / 1ps
`default_nettype none
module cfac_count (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        rd_en,
  input  wire logic [cfac_pkg::CHAR_W-1:0] rd_addr,
  input  wire cfac_pkg::cfac_cmd_t         cmd,
  output logic                             nz_zero
);

  logic [cfac_pkg::CNT_W-1:0]  rdata;
  logic [cfac_pkg::N_CHAR-1:0] vld_r, vld_nxt;
  logic [cfac_pkg::NZ_W-1:0]   nz_r, nz_nxt;
  logic                        fwd_vld_r;
  logic [cfac_pkg::CHAR_W-1:0] fwd_idx_r;
  logic [cfac_pkg::CNT_W-1:0]  fwd_data_r;
  logic [cfac_pkg::CNT_W-1:0]  cnt_old, after;

  cfac_ram #(
    .WIDTH(cfac_pkg::CNT_W),
    .DEPTH(cfac_pkg::N_CHAR)
  ) u_ram (
    .clk    (clk),
    .we     (cmd.upd),
    .waddr  (cmd.idx),
    .wdata  (after),
    .re     (rd_en),
    .raddr  (rd_addr),
    .rdata_r(rdata)
  );

  // Read data missed the write done on the edge that issued the read.
  always_comb begin
    if (!vld_r[cmd.idx]) begin
      cnt_old = '0;
    end else if (fwd_vld_r && fwd_idx_r == cmd.idx) begin
      cnt_old = fwd_data_r;
    end else begin
      cnt_old = rdata;
    end
    after = cmd.dec ? cnt_old - 1'b1 : cnt_old + 1'b1;
  end

  always_comb begin
    vld_nxt = vld_r;
    nz_nxt  = nz_r;
    if (cmd.clr) begin
      vld_nxt = '0;
      nz_nxt  = '0;
    end else if (cmd.upd) begin
      vld_nxt[cmd.idx] = 1'b1;
      if (cnt_old == '0) begin
        nz_nxt = nz_r + 1'b1;
      end else if (after == '0) begin
        nz_nxt = nz_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      nz_r      <= '0;
      fwd_vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      nz_r  <= nz_nxt;
      if (cmd.adv) begin
        fwd_vld_r <= cmd.upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.adv) begin
      fwd_idx_r  <= cmd.idx;
      fwd_data_r <= after;
    end
  end

  assign nz_zero = (nz_r == '0);

endmodule
`default_nettype wire

>>> sv/case_folded_anagram_checker.sv
// Top level of the case-folded anagram checker.
`timescale 1ns / 1ps
`default_nettype none
// Streams the characters of two strings, one word per character, tagged in
// in_tuser as first string, second string or end of pair; 'A'..'Z' fold to
// lower case, zero bytes and tag 3 are dropped. A 256-entry RAM of signed
// difference counts goes up for first-string characters and down for
// second-string ones, and a tally of nonzero entries is kept next to it. The
// end-of-pair word yields one result word: is_anagram in out_tdata[0], and
// length_overflow in out_tuser[0] when either string ran past MAX_LEN
// characters (extra characters are dropped, result then 0). After end of pair
// all state is empty again, cleared by dropping the per-entry valid bits, so
// there is no clearing pass after reset either. One word is taken per clock
// while in_tready is high: a word is read from the count RAM on the cycle it
// is accepted and written back the next, with the just-written entry
// forwarded to a following word that hits the same character. The result
// word is formed as the end-of-pair word leaves stage 1 and is held in the
// output register. in_tready drops only while an end-of-pair word waits for
// the output register to be taken.
module case_folded_anagram_checker #(
  parameter int MAX_LEN = cfac_pkg::MAX_LEN_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] character
  input  wire logic [1:0] in_tuser,   // [1:0] operation
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic      [7:0] out_tdata,  // [0] is_anagram, [7:1] zero
  output logic      [0:0] out_tuser   // [0] length_overflow
);

  localparam logic [cfac_pkg::LEN_W-1:0] LEN_MAX = cfac_pkg::LEN_W'(MAX_LEN);

  // stage 1: word whose count entry is being read
  logic                          s1_vld_r;
  logic [cfac_pkg::OP_W-1:0]     s1_op_r;
  logic [cfac_pkg::CHAR_W-1:0]   s1_idx_r;

  logic [cfac_pkg::LEN_W-1:0]    len1_r, len2_r;
  logic                          ovf_r;
  logic                          out_vld_r;
  logic                          out_ana_r, out_ovf_r;

  logic                          adv, acc, keep;
  logic [cfac_pkg::OP_W-1:0]     in_op;
  logic [cfac_pkg::CHAR_W-1:0]   in_ch, in_fold;
  logic                          is_end, is_char, is_first, full, do_upd;
  logic                          nz_zero;
  cfac_pkg::cfac_cmd_t           cmd;

  assign in_op   = in_tuser;
  assign in_ch   = in_tdata;
  assign in_fold = cfac_pkg::fold_case(in_ch);

  assign is_end   = s1_vld_r && s1_op_r == cfac_pkg::OP_END;
  assign is_char  = s1_vld_r && s1_op_r != cfac_pkg::OP_END;
  assign is_first = s1_op_r == cfac_pkg::OP_FIRST;
  assign full     = is_first ? (len1_r >= LEN_MAX) : (len2_r >= LEN_MAX);
  assign do_upd   = is_char && !full;

  // hold only an end-of-pair word that has no room in the output register
  assign adv       = !(is_end && out_vld_r && !out_tready);
  assign in_tready = adv;
  assign acc       = in_tvalid && adv;
  assign keep      = acc && (in_op == cfac_pkg::OP_END ||
                     (in_op inside {cfac_pkg::OP_FIRST, cfac_pkg::OP_SECOND} &&
                      in_ch != cfac_pkg::CH_NUL));

  always_comb begin
    cmd     = '0;
    cmd.adv = adv;
    cmd.upd = adv && do_upd;
    cmd.dec = !is_first;
    cmd.clr = adv && is_end;
    cmd.idx = s1_idx_r;
  end

  cfac_count u_count (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (acc),
    .rd_addr(in_fold),
    .cmd    (cmd),
    .nz_zero(nz_zero)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      len1_r    <= '0;
      len2_r    <= '0;
      ovf_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (adv) begin
        s1_vld_r <= keep;
        if (is_end) begin
          len1_r    <= '0;
          len2_r    <= '0;
          ovf_r     <= 1'b0;
          out_vld_r <= 1'b1;
        end else begin
          if (out_tready) begin
            out_vld_r <= 1'b0;
          end
          if (is_char && full) begin
            ovf_r <= 1'b1;
          end
          if (do_upd && is_first) begin
            len1_r <= len1_r + 1'b1;
          end
          if (do_upd && !is_first) begin
            len2_r <= len2_r + 1'b1;
          end
        end
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op_r  <= in_op;
      s1_idx_r <= in_fold;
      if (is_end) begin
        out_ana_r <= !ovf_r && len1_r == len2_r && nz_zero;
        out_ovf_r <= ovf_r;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'd0, out_ana_r};
  assign out_tuser  = out_ovf_r;

endmodule
`default_nettype wire

>>> sv/cfac_checker.sv
// Port-level checks for the case-folded anagram checker, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module cfac_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tvalid,
  input wire logic       in_tready,
  input wire logic [1:0] in_tuser,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic [0:0] out_tuser
);

  // a stalled result word stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result word after reset");

  // a fresh result follows an accepted end-of-pair word
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready && in_tuser == cfac_pkg::OP_END, 2))
    else $error("result word without end of pair");

  // input back-pressure only while the output register is full
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with empty output");

  a_ovf_not_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> !out_tdata[0])
    else $error("anagram reported with overflow");

endmodule

bind case_folded_anagram_checker cfac_checker u_cfac_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tuser  (in_tuser),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);
`default_nettype wire
